// ===== hdl/assert_macros.svh =====
// assertion macros shared by the thermistor converter rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while in reset
`define T2C_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("t2c check failed");

// antecedent now, consequent on the following edge
`define T2C_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("t2c check failed");

`endif

// ===== hdl/t2c_pkg.sv =====
// widths, constants and shared types of the thermistor to celsius converter
// no dependencies
package t2c_pkg;

    localparam int VOLT_W    = 13;
    localparam int SER_W     = 20;
    localparam int SUP_W     = 13;
    localparam int COEF_W    = 40;
    localparam int COEF_H    = COEF_W / 2;
    localparam int TEMP_W    = 18;
    localparam int CFG_IDX_W = 3;

    localparam int NUM_W   = SER_W + SUP_W;
    localparam int RQ_FRAC = 16;
    localparam int RQ_W    = NUM_W + RQ_FRAC;
    localparam int ZC_W    = 6;
    localparam int MANT_W  = 31;
    localparam int FRAC_W  = 24;
    localparam int IP_W    = 7;
    localparam int LOG_W   = IP_W + FRAC_W;
    localparam int MAG_W   = 30;

    localparam int LN2_W   = 32;
    localparam logic [LN2_W-1:0] LN2_Q32 = 32'd2977044472;
    localparam int LM_SH   = 40;
    localparam int LM_W    = 22;
    localparam int L_FRAC  = 16;
    localparam int L2_W    = 28;
    localparam int L3_W    = 34;
    localparam int L3_H    = 17;
    localparam int TB_W    = 46;
    localparam int TC_W    = 58;
    localparam int SUM_W   = 59;
    localparam int D_W     = 61;
    localparam int KNUM_W  = 60;
    localparam int KQ_W    = 17;

    localparam logic [KNUM_W-1:0] KELVIN_NUM = 60'd28147497671065600;
    localparam logic [KQ_W-1:0]   K_MAX      = 17'd127314;
    localparam logic [TEMP_W-1:0] ZERO_C_CDEG = 18'd27315;
    localparam logic signed [TEMP_W-1:0] TEMP_LO = -18'sd27315;
    localparam logic signed [TEMP_W-1:0] TEMP_HI = 18'sd99999;

    localparam logic [SER_W-1:0]  SER_RST  = 20'd10000;
    localparam logic [SUP_W-1:0]  SUP_RST  = 13'd5000;
    localparam logic [COEF_W-1:0] COEF_A_RST = 40'd284078485700;
    localparam logic [COEF_W-1:0] COEF_B_RST = 40'd66946161695;
    localparam logic [COEF_W-1:0] COEF_C_RST = 40'd56835503;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SERIES = 3'd0,
        REG_SUPPLY = 3'd1,
        REG_COEF_A = 3'd2,
        REG_COEF_B = 3'd3,
        REG_COEF_C = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic vld;
        logic ok;
    } t2c_tag_t;

endpackage

// ===== hdl/t2c_in_if.sv =====
// input channel of the converter: one voltage item per handshake
// depends on t2c_pkg
interface t2c_in_if
    import t2c_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [VOLT_W-1:0] voltage_mv;

    modport source (output valid, output voltage_mv, input ready);
    modport sink (input valid, input voltage_mv, output ready);
endinterface

// ===== hdl/t2c_out_if.sv =====
// output channel of the converter: one temperature item per handshake
// depends on t2c_pkg
interface t2c_out_if
    import t2c_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature_cdeg;
    logic                     valid_res;

    modport source (output valid, output temperature_cdeg, output valid_res, input ready);
    modport sink (input valid, input temperature_cdeg, input valid_res, output ready);
endinterface

// ===== hdl/t2c_rdiv.sv =====
// pipelined restoring divider for the thermistor resistance, one quotient bit per stage
// depends on t2c_pkg
module t2c_rdiv
    import t2c_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  t2c_tag_t          tag_in,
    input  logic [NUM_W-1:0]  num_in,
    input  logic [VOLT_W-1:0] den_in,
    output t2c_tag_t          tag_out,
    output logic [RQ_W-1:0]   quo_out
);

    localparam int STAGES = RQ_W;

    t2c_tag_t          tag_reg [STAGES];
    logic [VOLT_W-1:0] rem_reg [STAGES];
    logic [VOLT_W-1:0] den_reg [STAGES];
    logic [RQ_W-1:0]   wrd_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        t2c_tag_t          tag_prev;
        logic [VOLT_W-1:0] rem_prev;
        logic [VOLT_W-1:0] den_prev;
        logic [RQ_W-1:0]   wrd_prev;
        logic [VOLT_W:0]   trial;
        logic              ge;

        if (s == 0)
        begin : g_first
            assign tag_prev = tag_in;
            assign rem_prev = '0;
            assign den_prev = den_in;
            assign wrd_prev = {num_in, {RQ_FRAC{1'b0}}};
        end
        else
        begin : g_next
            assign tag_prev = tag_reg[s-1];
            assign rem_prev = rem_reg[s-1];
            assign den_prev = den_reg[s-1];
            assign wrd_prev = wrd_reg[s-1];
        end

        // partial remainder takes the next numerator bit from the top of the word
        assign trial = {rem_prev, wrd_prev[RQ_W-1]};
        assign ge    = trial >= {1'b0, den_prev};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tag_reg[s] <= '0;
            else if (adv)
                tag_reg[s] <= tag_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s] <= ge ? VOLT_W'(trial - {1'b0, den_prev}) : trial[VOLT_W-1:0];
                den_reg[s] <= den_prev;
                wrd_reg[s] <= {wrd_prev[RQ_W-2:0], ge};
            end
        end
    end

    assign tag_out = tag_reg[STAGES-1];
    assign quo_out = wrd_reg[STAGES-1];

endmodule

// ===== hdl/t2c_log2.sv =====
// pipelined base-2 log of the q16 resistance: normalise, then one squaring per fraction bit
// depends on t2c_pkg and assert_macros.svh
`include "assert_macros.svh"

module t2c_log2
    import t2c_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  t2c_tag_t                tag_in,
    input  logic [RQ_W-1:0]         rq_in,
    output t2c_tag_t                tag_out,
    output logic signed [LOG_W-1:0] lg_out
);

    localparam int NORM_ST = ZC_W;
    localparam int SQ_ST   = FRAC_W;
    localparam int SQ_W    = 2 * MANT_W;
    localparam int IP_BIAS = RQ_W - 1 - RQ_FRAC;

    t2c_tag_t          ntag_reg [NORM_ST];
    logic [RQ_W-1:0]   nw_reg   [NORM_ST];
    logic [ZC_W-1:0]   nz_reg   [NORM_ST];
    t2c_tag_t          qtag_reg [SQ_ST];
    logic [MANT_W-1:0] x_reg    [SQ_ST];
    logic [FRAC_W-1:0] f_reg    [SQ_ST];
    logic [IP_W-1:0]   ip_reg   [SQ_ST];

    // leading-zero shift, widest step first
    for (genvar s = 0; s < NORM_ST; s++)
    begin : g_norm
        localparam int SH = 1 << (NORM_ST - 1 - s);
        t2c_tag_t        tag_prev;
        logic [RQ_W-1:0] w_prev;
        logic [ZC_W-1:0] z_prev;
        logic            top_zero;

        if (s == 0)
        begin : g_first
            assign tag_prev = tag_in;
            assign w_prev   = rq_in;
            assign z_prev   = '0;
        end
        else
        begin : g_next
            assign tag_prev = ntag_reg[s-1];
            assign w_prev   = nw_reg[s-1];
            assign z_prev   = nz_reg[s-1];
        end

        assign top_zero = (w_prev[RQ_W-1 -: SH] == '0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ntag_reg[s] <= '0;
            else if (adv)
                ntag_reg[s] <= tag_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                nw_reg[s] <= top_zero ? (w_prev << SH) : w_prev;
                nz_reg[s] <= top_zero ? (z_prev | ZC_W'(SH)) : z_prev;
            end
        end
    end

    // mantissa squaring, one fraction bit per stage
    for (genvar s = 0; s < SQ_ST; s++)
    begin : g_sq
        t2c_tag_t          tag_prev;
        logic [MANT_W-1:0] x_prev;
        logic [FRAC_W-1:0] f_prev;
        logic [IP_W-1:0]   ip_prev;
        logic [SQ_W-1:0]   sq;
        logic [MANT_W:0]   y;

        if (s == 0)
        begin : g_first
            assign tag_prev = ntag_reg[NORM_ST-1];
            assign x_prev   = nw_reg[NORM_ST-1][RQ_W-1 -: MANT_W];
            assign f_prev   = '0;
            assign ip_prev  = IP_W'(IP_BIAS) - IP_W'(nz_reg[NORM_ST-1]);
        end
        else
        begin : g_next
            assign tag_prev = qtag_reg[s-1];
            assign x_prev   = x_reg[s-1];
            assign f_prev   = f_reg[s-1];
            assign ip_prev  = ip_reg[s-1];
        end

        assign sq = SQ_W'(x_prev) * SQ_W'(x_prev);
        assign y  = sq[SQ_W-1 -: MANT_W+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                qtag_reg[s] <= '0;
            else if (adv)
                qtag_reg[s] <= tag_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[s]  <= y[MANT_W] ? y[MANT_W:1] : y[MANT_W-1:0];
                f_reg[s]  <= {f_prev[FRAC_W-2:0], y[MANT_W]};
                ip_reg[s] <= ip_prev;
            end
        end
    end

    assign tag_out = qtag_reg[SQ_ST-1];
    assign lg_out  = {ip_reg[SQ_ST-1], f_reg[SQ_ST-1]};

    `T2C_ASSERT(a_norm_top, ntag_reg[NORM_ST-1].vld && ntag_reg[NORM_ST-1].ok |-> nw_reg[NORM_ST-1][RQ_W-1])
    `T2C_ASSERT_NEXT(a_sq_norm, adv && ntag_reg[NORM_ST-1].vld && ntag_reg[NORM_ST-1].ok, x_reg[0][MANT_W-1])

endmodule

// ===== hdl/thermistor_to_celsius_unit.sv =====
// NTC thermistor to celsius converter: takes one divider voltage item per clock unless the output
// stalls and presents the Steinhart-Hart temperature in hundredths of a degree. The pipeline is the
// entry register, the 49-stage restoring divider for the resistance, the 30-stage log2 unit (6
// normalise stages and 24 squaring stages), 11 polynomial stages, the 17-stage reciprocal divider and
// the output register. The whole pipeline holds while a result waits, so items are never dropped.
// Voltage zero, at or above supply, or a zero series resistor gives valid_res 0 and temperature 0.
// The user must write registers only while the block holds no item; the block does not enforce it.
// depends on t2c_pkg, t2c_in_if, t2c_out_if, t2c_rdiv, t2c_log2 and assert_macros.svh
`include "assert_macros.svh"

module thermistor_to_celsius_unit
    import t2c_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    t2c_in_if.sink               sample,
    t2c_out_if.source            result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [COEF_W-1:0]    cfg_data
);

    localparam int LMP_W = MAG_W + LN2_W;
    localparam int TBP_W = COEF_W + LM_W;
    localparam int PP_W  = COEF_H + L3_H;
    localparam int CL_W  = COEF_H + L3_W;
    localparam int TCS_W = COEF_W + L3_W;
    localparam int DIV_W = KNUM_W + KQ_W;

    typedef struct packed {
        logic over;
        logic dz;
        logic dn;
    } kflag_t;

    logic [SER_W-1:0]  ser_reg;
    logic [SUP_W-1:0]  sup_reg;
    logic [COEF_W-1:0] ca_reg;
    logic [COEF_W-1:0] cb_reg;
    logic [COEF_W-1:0] cc_reg;

    logic adv;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_reg <= SER_RST;
            sup_reg <= SUP_RST;
            ca_reg  <= COEF_A_RST;
            cb_reg  <= COEF_B_RST;
            cc_reg  <= COEF_C_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_idx))
                REG_SERIES: ser_reg <= cfg_data[SER_W-1:0];
                REG_SUPPLY: sup_reg <= cfg_data[SUP_W-1:0];
                REG_COEF_A: ca_reg  <= cfg_data;
                REG_COEF_B: cb_reg  <= cfg_data;
                REG_COEF_C: cc_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // entry stage
    t2c_tag_t         s0_tag_reg;
    logic [NUM_W-1:0] s0_num_reg;
    logic [VOLT_W-1:0] s0_den_reg;
    logic             in_ok;
    logic [SUP_W-1:0] diff;

    assign in_ok = (sample.voltage_mv != '0) && (sample.voltage_mv < sup_reg) && (ser_reg != '0);
    assign diff  = sup_reg - sample.voltage_mv;

    // resistance and log
    t2c_tag_t               dv_tag;
    logic [RQ_W-1:0]        dv_quo;
    t2c_tag_t               lg_tag;
    logic signed [LOG_W-1:0] lg_val;

    t2c_rdiv u_rdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag_in  (s0_tag_reg),
        .num_in  (s0_num_reg),
        .den_in  (s0_den_reg),
        .tag_out (dv_tag),
        .quo_out (dv_quo)
    );

    t2c_log2 u_log2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag_in  (dv_tag),
        .rq_in   (dv_quo),
        .tag_out (lg_tag),
        .lg_out  (lg_val)
    );

    // polynomial stages
    t2c_tag_t s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg, s5_tag_reg, s6_tag_reg;
    t2c_tag_t s7_tag_reg, s8_tag_reg, s9_tag_reg, s10_tag_reg, s11_tag_reg;
    logic s1_neg_reg, s2_neg_reg, s3_neg_reg, s4_neg_reg, s5_neg_reg, s6_neg_reg;
    logic s7_neg_reg, s8_neg_reg;
    logic [MAG_W-1:0]  s1_mag_reg;
    logic [LM_W-1:0]   s2_lm_reg;
    logic [LM_W-1:0]   s3_lm_reg;
    logic [L2_W-1:0]   s3_l2_reg;
    logic [TBP_W-COEF_H-1:0] s3_tbh_reg;
    logic [TBP_W-COEF_H-1:0] s3_tbl_reg;
    logic [L3_W-1:0]   s4_l3_reg;
    logic [TB_W-1:0]   s4_tb_reg, s5_tb_reg, s6_tb_reg, s7_tb_reg;
    logic [PP_W-1:0]   s5_hh_reg, s5_hl_reg, s5_lh_reg, s5_ll_reg;
    logic [CL_W-1:0]   s6_ch_reg, s6_cl_reg;
    logic [TC_W-1:0]   s7_tc_reg;
    logic [SUM_W-1:0]  s8_sum_reg;
    logic [D_W-1:0]    s9_d_reg;
    logic              s10_dz_reg, s10_dn_reg;
    logic [KNUM_W-1:0] s10_ud_reg, s10_num_reg;
    kflag_t            s11_flag_reg;
    logic [KNUM_W-1:0] s11_ud_reg, s11_num_reg;

    logic [LMP_W-1:0] lm_sum;
    logic [2*LM_W-1:0] l2_prod;
    logic [L2_W+LM_W-1:0] l3_prod;
    logic [TBP_W-1:0] tb_sum;
    logic [TCS_W-1:0] tc_sum;
    logic [D_W-1:0]   d_next;

    assign lm_sum  = LMP_W'(s1_mag_reg) * LMP_W'(LN2_Q32) + (LMP_W'(1) << (LM_SH - 1));
    assign l2_prod = (2*LM_W)'(s2_lm_reg) * (2*LM_W)'(s2_lm_reg);
    assign l3_prod = (L2_W+LM_W)'(s3_l2_reg) * (L2_W+LM_W)'(s3_lm_reg);
    assign tb_sum  = (TBP_W'(s3_tbh_reg) << COEF_H) + TBP_W'(s3_tbl_reg);
    assign tc_sum  = (TCS_W'(s6_ch_reg) << COEF_H) + TCS_W'(s6_cl_reg);
    assign d_next  = s8_neg_reg ? D_W'(ca_reg) - D_W'(s8_sum_reg)
                                : D_W'(ca_reg) + D_W'(s8_sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_tag_reg  <= '0;
            s1_tag_reg  <= '0;
            s2_tag_reg  <= '0;
            s3_tag_reg  <= '0;
            s4_tag_reg  <= '0;
            s5_tag_reg  <= '0;
            s6_tag_reg  <= '0;
            s7_tag_reg  <= '0;
            s8_tag_reg  <= '0;
            s9_tag_reg  <= '0;
            s10_tag_reg <= '0;
            s11_tag_reg <= '0;
        end
        else if (adv)
        begin
            s0_tag_reg  <= '{vld: sample.valid, ok: in_ok};
            s1_tag_reg  <= lg_tag;
            s2_tag_reg  <= s1_tag_reg;
            s3_tag_reg  <= s2_tag_reg;
            s4_tag_reg  <= s3_tag_reg;
            s5_tag_reg  <= s4_tag_reg;
            s6_tag_reg  <= s5_tag_reg;
            s7_tag_reg  <= s6_tag_reg;
            s8_tag_reg  <= s7_tag_reg;
            s9_tag_reg  <= s8_tag_reg;
            s10_tag_reg <= s9_tag_reg;
            s11_tag_reg <= s10_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_num_reg <= NUM_W'(ser_reg) * NUM_W'(diff);
            s0_den_reg <= sample.voltage_mv;

            s1_neg_reg <= lg_val[LOG_W-1];
            s1_mag_reg <= lg_val[LOG_W-1] ? MAG_W'(-lg_val) : MAG_W'(lg_val);

            s2_neg_reg <= s1_neg_reg;
            s2_lm_reg  <= lm_sum[LM_SH +: LM_W];

            s3_neg_reg <= s2_neg_reg;
            s3_lm_reg  <= s2_lm_reg;
            s3_l2_reg  <= l2_prod[L_FRAC +: L2_W];
            s3_tbh_reg <= (TBP_W-COEF_H)'(cb_reg[COEF_W-1:COEF_H]) * (TBP_W-COEF_H)'(s2_lm_reg);
            s3_tbl_reg <= (TBP_W-COEF_H)'(cb_reg[COEF_H-1:0]) * (TBP_W-COEF_H)'(s2_lm_reg);

            s4_neg_reg <= s3_neg_reg;
            s4_l3_reg  <= l3_prod[L_FRAC +: L3_W];
            s4_tb_reg  <= tb_sum[L_FRAC +: TB_W];

            s5_neg_reg <= s4_neg_reg;
            s5_tb_reg  <= s4_tb_reg;
            s5_hh_reg  <= PP_W'(cc_reg[COEF_W-1:COEF_H]) * PP_W'(s4_l3_reg[L3_W-1:L3_H]);
            s5_hl_reg  <= PP_W'(cc_reg[COEF_W-1:COEF_H]) * PP_W'(s4_l3_reg[L3_H-1:0]);
            s5_lh_reg  <= PP_W'(cc_reg[COEF_H-1:0]) * PP_W'(s4_l3_reg[L3_W-1:L3_H]);
            s5_ll_reg  <= PP_W'(cc_reg[COEF_H-1:0]) * PP_W'(s4_l3_reg[L3_H-1:0]);

            s6_neg_reg <= s5_neg_reg;
            s6_tb_reg  <= s5_tb_reg;
            s6_ch_reg  <= (CL_W'(s5_hh_reg) << L3_H) + CL_W'(s5_hl_reg);
            s6_cl_reg  <= (CL_W'(s5_lh_reg) << L3_H) + CL_W'(s5_ll_reg);

            s7_neg_reg <= s6_neg_reg;
            s7_tb_reg  <= s6_tb_reg;
            s7_tc_reg  <= tc_sum[L_FRAC +: TC_W];

            s8_neg_reg <= s7_neg_reg;
            s8_sum_reg <= SUM_W'(s7_tb_reg) + SUM_W'(s7_tc_reg);

            s9_d_reg   <= d_next;

            s10_dz_reg  <= (s9_d_reg == '0);
            s10_dn_reg  <= s9_d_reg[D_W-1];
            s10_ud_reg  <= s9_d_reg[KNUM_W-1:0];
            s10_num_reg <= KELVIN_NUM + s9_d_reg[KNUM_W:1];

            s11_flag_reg <= '{over: DIV_W'(s10_num_reg) >= (DIV_W'(s10_ud_reg) << KQ_W),
                              dz: s10_dz_reg, dn: s10_dn_reg};
            s11_ud_reg   <= s10_ud_reg;
            s11_num_reg  <= s10_num_reg;
        end
    end

    // reciprocal divider, one kelvin quotient bit per stage
    t2c_tag_t          kd_tag_reg  [KQ_W];
    kflag_t            kd_flag_reg [KQ_W];
    logic [KNUM_W-1:0] kd_rem_reg  [KQ_W];
    logic [KNUM_W-1:0] kd_ud_reg   [KQ_W];
    logic [KQ_W-1:0]   kd_q_reg    [KQ_W];

    for (genvar k = 0; k < KQ_W; k++)
    begin : g_kdiv
        localparam int SH = KQ_W - 1 - k;
        t2c_tag_t          tag_prev;
        kflag_t            flag_prev;
        logic [KNUM_W-1:0] rem_prev;
        logic [KNUM_W-1:0] ud_prev;
        logic [KQ_W-1:0]   q_prev;
        logic [DIV_W-1:0]  dsh;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign tag_prev  = s11_tag_reg;
            assign flag_prev = s11_flag_reg;
            assign rem_prev  = s11_num_reg;
            assign ud_prev   = s11_ud_reg;
            assign q_prev    = '0;
        end
        else
        begin : g_next
            assign tag_prev  = kd_tag_reg[k-1];
            assign flag_prev = kd_flag_reg[k-1];
            assign rem_prev  = kd_rem_reg[k-1];
            assign ud_prev   = kd_ud_reg[k-1];
            assign q_prev    = kd_q_reg[k-1];
        end

        assign dsh = DIV_W'(ud_prev) << SH;
        assign ge  = DIV_W'(rem_prev) >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                kd_tag_reg[k] <= '0;
            else if (adv)
                kd_tag_reg[k] <= tag_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                kd_flag_reg[k] <= flag_prev;
                kd_rem_reg[k]  <= ge ? KNUM_W'(DIV_W'(rem_prev) - dsh) : rem_prev;
                kd_ud_reg[k]   <= ud_prev;
                kd_q_reg[k]    <= {q_prev[KQ_W-2:0], ge};
            end
        end
    end

    // saturation and output register
    t2c_tag_t                 kd_tag;
    kflag_t                   kd_flag;
    logic [KQ_W-1:0]          kd_q;
    logic signed [TEMP_W-1:0] temp_next;
    logic                     res_vld_reg;
    logic signed [TEMP_W-1:0] res_temp_reg;
    logic                     res_ok_reg;

    assign kd_tag  = kd_tag_reg[KQ_W-1];
    assign kd_flag = kd_flag_reg[KQ_W-1];
    assign kd_q    = kd_q_reg[KQ_W-1];

    always_comb
    begin
        priority if (!kd_tag.ok)
            temp_next = '0;
        else if (kd_flag.dz)
            temp_next = TEMP_HI;
        else if (kd_flag.dn)
            temp_next = TEMP_LO;
        else if (kd_flag.over || (kd_q > K_MAX))
            temp_next = TEMP_HI;
        else
            temp_next = TEMP_W'(kd_q) - ZERO_C_CDEG;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (adv)
            res_vld_reg <= kd_tag.vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_temp_reg <= temp_next;
            res_ok_reg   <= kd_tag.ok;
        end
    end

    assign adv                     = !res_vld_reg || result.ready;
    assign sample.ready            = adv;
    assign result.valid            = res_vld_reg;
    assign result.temperature_cdeg = res_temp_reg;
    assign result.valid_res        = res_ok_reg;

    `T2C_ASSERT(a_bad_zero, result.valid && !result.valid_res |-> result.temperature_cdeg == '0)
    `T2C_ASSERT(a_temp_range, result.valid |-> (result.temperature_cdeg >= TEMP_LO) && (result.temperature_cdeg <= TEMP_HI))
    `T2C_ASSERT(a_stall_full, !sample.ready |-> result.valid)

endmodule

// ===== tb/tb_thermistor_to_celsius_unit.sv =====
// self-checking testbench of thermistor_to_celsius_unit: voltage items in, temperature items out,
// each result compared with a local fixed-point Steinhart-Hart predictor or a given value, over several settings
// depends on t2c_pkg, t2c_in_if, t2c_out_if and thermistor_to_celsius_unit
module tb_thermistor_to_celsius_unit;
    import t2c_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int LIMIT_CYCLES = 500000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic                     ok;
    } temp_item_t;

    typedef struct {
        logic [VOLT_W-1:0]        volt;
        bit                       typed;
        logic signed [TEMP_W-1:0] temp;
        logic                     ok;
    } volt_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [COEF_W-1:0] cfg_data;

    t2c_in_if  sample_if ();
    t2c_out_if result_if ();

    thermistor_to_celsius_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_if.sink),
        .result   (result_if.source),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    longint unsigned series_ohm;
    longint unsigned supply;
    longint unsigned coef_a;
    longint unsigned coef_b;
    longint unsigned coef_c;

    temp_item_t expected_temps[$];
    int errors = 0;
    int items_sent;
    int send_idle;
    int recv_idle;
    int cycles = 0;

    volt_row_t directed_rows[] = '{
        '{13'd0,    1'b1, 18'sd0, 1'b0},
        '{13'd5000, 1'b1, 18'sd0, 1'b0},
        '{13'd8191, 1'b1, 18'sd0, 1'b0},
        '{13'd7000, 1'b1, 18'sd0, 1'b0},
        '{13'd1,    1'b0, 18'sd0, 1'b0},
        '{13'd2,    1'b0, 18'sd0, 1'b0},
        '{13'd8,    1'b0, 18'sd0, 1'b0},
        '{13'd100,  1'b0, 18'sd0, 1'b0},
        '{13'd1000, 1'b0, 18'sd0, 1'b0},
        '{13'd2500, 1'b0, 18'sd0, 1'b0},
        '{13'd4096, 1'b0, 18'sd0, 1'b0},
        '{13'd4000, 1'b0, 18'sd0, 1'b0},
        '{13'd4990, 1'b0, 18'sd0, 1'b0},
        '{13'd4999, 1'b0, 18'sd0, 1'b0}
    };

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb_thermistor_to_celsius_unit: errors");
            $finish;
        end
    end

    function automatic longint unsigned mul_q16(longint unsigned a, longint unsigned b);
        return a * (b >> 16) + ((a * (b & 64'hFFFF)) >> 16);
    endfunction

    function automatic temp_item_t convert_voltage(logic [VOLT_W-1:0] volt);
        temp_item_t res;
        longint unsigned v, rq, x, frac, mag, lmag, l2, l3, tb, tc, ud, k;
        longint log2q, d, t;
        bit neg;
        int n;
        v = volt;
        res.temp = '0;
        res.ok = 1'b0;
        if (v == 0 || v >= supply || series_ohm == 0)
            return res;
        rq = ((series_ohm * (supply - v)) << 16) / v;
        n = 0;
        x = rq;
        while (x > 1)
        begin
            x = x >> 1;
            n++;
        end
        x = (n >= 30) ? (rq >> (n - 30)) : (rq << (30 - n));
        frac = 0;
        for (int i = 0; i < FRAC_W; i++)
        begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= 64'd2147483648)
            begin
                x = x >> 1;
                frac = frac | 64'd1;
            end
        end
        log2q = longint'(n - 16) * 64'sd16777216 + longint'(frac);
        neg = log2q < 0;
        mag = neg ? longint'(-log2q) : log2q;
        lmag = (mag * longint'(LN2_Q32) + (64'd1 << 39)) >> 40;
        l2 = (lmag * lmag) >> 16;
        l3 = (l2 * lmag) >> 16;
        tb = mul_q16(coef_b, lmag);
        tc = mul_q16(coef_c, l3);
        d = longint'(coef_a);
        if (neg)
            d = d - longint'(tb + tc);
        else
            d = d + longint'(tb + tc);
        if (d == 0)
            t = TEMP_HI;
        else if (d < 0)
            t = TEMP_LO;
        else
        begin
            ud = d;
            k = (longint'(KELVIN_NUM) + ud / 2) / ud;
            if (k > longint'(TEMP_HI) + longint'(ZERO_C_CDEG))
                t = TEMP_HI;
            else
                t = longint'(k) - longint'(ZERO_C_CDEG);
        end
        res.temp = t[TEMP_W-1:0];
        res.ok = 1'b1;
        return res;
    endfunction

    // receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
            result_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    // result check, values are stable from the falling edge to the accepting edge
    always @(negedge clk)
    begin
        temp_item_t exp_item;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_temps.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected item: temp %0d ok %0b",
                             result_if.temperature_cdeg, result_if.valid_res);
            end
            else
            begin
                exp_item = expected_temps.pop_front();
                if (result_if.temperature_cdeg !== exp_item.temp
                    || result_if.valid_res !== exp_item.ok)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected temp %0d ok %0b, got temp %0d ok %0b",
                                 exp_item.temp, exp_item.ok,
                                 result_if.temperature_cdeg, result_if.valid_res);
                end
            end
        end
    end

    task automatic send_item(logic [VOLT_W-1:0] volt, bit typed, temp_item_t typed_res);
        bit go;
        if (items_sent < 700)
        begin
            send_idle = 7;
            recv_idle = 71;
        end
        else if (items_sent < 1400)
        begin
            send_idle = 71;
            recv_idle = 7;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
        while ($urandom_range(99) < send_idle)
        begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid <= 1'b1;
        sample_if.voltage_mv <= volt;
        forever
        begin
            @(negedge clk);
            go = sample_if.ready;
            @(posedge clk);
            if (go)
                break;
        end
        expected_temps.push_back(typed ? typed_res : convert_voltage(volt));
        items_sent++;
    endtask

    task automatic wait_idle();
        sample_if.valid <= 1'b0;
        while (expected_temps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SERIES: series_ohm = data[SER_W-1:0];
            REG_SUPPLY: supply = data[SUP_W-1:0];
            REG_COEF_A: coef_a = data;
            REG_COEF_B: coef_b = data;
            REG_COEF_C: coef_c = data;
            default: ;
        endcase
    endtask

    task automatic write_all(longint unsigned ser, longint unsigned sup, longint unsigned a,
                             longint unsigned b, longint unsigned c);
        write_reg(REG_SERIES, COEF_W'(ser));
        write_reg(REG_SUPPLY, COEF_W'(sup));
        write_reg(REG_COEF_A, COEF_W'(a));
        write_reg(REG_COEF_B, COEF_W'(b));
        write_reg(REG_COEF_C, COEF_W'(c));
    endtask

    function automatic logic [VOLT_W-1:0] pick_voltage();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70 && supply > 1)
            return VOLT_W'($urandom_range(int'(supply) - 1, 1));
        else if (sel < 75)
            return '0;
        else if (sel < 85)
            return VOLT_W'($urandom_range(8191, int'(supply)));
        else
            return VOLT_W'($urandom_range(8191));
    endfunction

    task automatic random_items(int count);
        temp_item_t none;
        none = '{temp: '0, ok: 1'b0};
        for (int i = 0; i < count; i++)
            send_item(pick_voltage(), 1'b0, none);
    endtask

    function automatic logic [COEF_W-1:0] rand_coef();
        return COEF_W'({$urandom, $urandom});
    endfunction

    initial
    begin
        temp_item_t typed_res;
        items_sent = 0;
        send_idle = 7;
        recv_idle = 71;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_SERIES;
        cfg_data = '0;
        sample_if.valid = 1'b0;
        sample_if.voltage_mv = '0;
        series_ohm = SER_RST;
        supply = SUP_RST;
        coef_a = COEF_A_RST;
        coef_b = COEF_B_RST;
        coef_c = COEF_C_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            typed_res = '{temp: directed_rows[i].temp, ok: directed_rows[i].ok};
            send_item(directed_rows[i].volt, directed_rows[i].typed, typed_res);
        end
        random_items(500);
        wait_idle();

        // zero series resistor and an ignored register index
        write_reg(REG_SERIES, '0);
        write_reg(REG_UNUSED, 40'hFF_FFFF_FFFF);
        random_items(80);
        wait_idle();

        // upper extremes of supply and coefficients, with a large series resistor
        write_all(1000000, 8191, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
        random_items(200);
        wait_idle();

        // zero denominator everywhere
        write_all(10000, 5000, 0, 0, 0);
        random_items(120);
        wait_idle();

        // tiny resistance with no constant term drives the denominator negative
        write_all(1, 8191, 0, COEF_B_RST, COEF_C_RST);
        random_items(150);
        wait_idle();

        // small constant term gives hot saturation
        write_all(1000000, 8191, 1, 0, 0);
        random_items(120);
        wait_idle();

        // supply of 1: every voltage out of range
        write_all(1, 1, COEF_A_RST, COEF_B_RST, COEF_C_RST);
        random_items(50);
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            if (p % 2 == 0)
                write_all($urandom_range(1000000, 1), $urandom_range(8191, 1),
                          rand_coef(), rand_coef(), rand_coef());
            else
                write_all($urandom_range(200000, 100), $urandom_range(8191, 500),
                          COEF_A_RST + $urandom_range(1 << 24),
                          COEF_B_RST - $urandom_range(1 << 24),
                          COEF_C_RST + $urandom_range(1 << 16));
            random_items(110);
            wait_idle();
        end

        sample_if.valid <= 1'b0;
        while (expected_temps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_thermistor_to_celsius_unit: clean");
        else
            $display("tb_thermistor_to_celsius_unit: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/t2c_pkg.sv
hdl/t2c_in_if.sv
hdl/t2c_out_if.sv
hdl/t2c_rdiv.sv
hdl/t2c_log2.sv
hdl/thermistor_to_celsius_unit.sv
tb/tb_thermistor_to_celsius_unit.sv
